// ----- src/lz4d_pkg.sv -----
// shared types and constants of the lz4 block decoder
// used by the front parser, the command queue and the back copy engine
`default_nettype none

package lz4d_pkg;

	// width of a copy count within one request (counts up to 127 bytes)
	localparam int CNT_W = 7;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_PENDING = 3'd1;
	localparam logic [2:0] ST_DONE    = 3'd2;
	localparam logic [2:0] ST_ERROR   = 3'd3;
	localparam logic [2:0] ST_BUSY    = 3'd4;

	// request kinds
	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// work handed from the parser to the copy engine
	typedef enum logic [1:0] {
		CMD_EMPTY = 2'd0,
		CMD_LIT   = 2'd1,
		CMD_COPY  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       lit;
		logic [CNT_W-1:0] cnt;
		logic [15:0]      off;
		logic [15:0]      wp;
		logic [2:0]       status;
	} cmd_t;

endpackage

`default_nettype wire

// ----- src/lz4d_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lz4d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/lz4d_cmd_fifo.sv -----
// two-entry command queue between the parser and the copy engine
// depends on lz4d_pkg
`default_nettype none

module lz4d_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  lz4d_pkg::cmd_t     push_cmd,
	output logic               full,
	input  wire logic          pop,
	output lz4d_pkg::cmd_t     pop_cmd,
	output logic               pop_valid
);
	import lz4d_pkg::*;

	cmd_t       buf_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_cmd   = buf_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/lz4d_front.sv -----
// sequence parser: token, lengths, literals, offset; one command per request
// depends on lz4d_pkg
`default_nettype none

module lz4d_front #(
	parameter int MAX_BYTES_PER_ITEM = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] dest_size,
	input  wire logic        accept,
	input  wire logic        req_type,
	input  wire logic [7:0]  in_byte,
	input  wire logic        last_in,
	output lz4d_pkg::cmd_t   cmd
);
	import lz4d_pkg::*;

	typedef enum logic [8:0] {
		PH_TOKEN  = 9'b000000001,
		PH_LITLEN = 9'b000000010,
		PH_LIT    = 9'b000000100,
		PH_OFFLO  = 9'b000001000,
		PH_OFFHI  = 9'b000010000,
		PH_MATLEN = 9'b000100000,
		PH_COPY   = 9'b001000000,
		PH_DONE   = 9'b010000000,
		PH_ERROR  = 9'b100000000
	} phase_t;

	phase_t      ph_q, ph_n;
	logic [15:0] wp_q, wp_n;
	logic [7:0]  tok_q, tok_n;
	logic [15:0] lit_q, lit_n;
	logic [15:0] ml_q, ml_n;
	logic [15:0] off_q, off_n;
	logic        src_q, src_n;

	function automatic logic [15:0] room_f(input logic [15:0] wp, input logic [15:0] dest);
		return (wp >= dest) ? 16'd0 : dest - wp;
	endfunction

	function automatic phase_t after_lit_f(input logic [15:0] wp, input logic [15:0] dest);
		return (({1'b0, wp} + 17'd8) > {1'b0, dest}) ? PH_DONE : PH_OFFLO;
	endfunction

	// next state and command for the accepted request
	always_comb begin
		logic [15:0]      room;
		logic [16:0]      sum;
		logic [15:0]      ml;
		logic             do_copy;
		logic             busy;
		logic [CNT_W-1:0] n;

		ph_n  = ph_q;
		wp_n  = wp_q;
		tok_n = tok_q;
		lit_n = lit_q;
		ml_n  = ml_q;
		off_n = off_q;
		src_n = src_q;
		room  = room_f(wp_q, dest_size);
		sum   = '0;
		ml    = '0;
		do_copy = 1'b0;
		busy  = 1'b0;
		n     = '0;
		cmd   = '0;
		cmd.kind = CMD_EMPTY;

		if (req_type == REQ_DRAIN) begin
			do_copy = (ph_q == PH_COPY);
		end else if (ph_q == PH_COPY) begin
			busy = 1'b1;
		end else if (ph_q != PH_DONE && ph_q != PH_ERROR) begin
			if (last_in) begin
				src_n = 1'b1;
			end
			case (ph_q)
				PH_TOKEN: begin
					tok_n = in_byte;
					lit_n = {12'd0, in_byte[7:4]};
					if (in_byte[7:4] == 4'hf && !last_in) begin
						ph_n = (16'd15 > room) ? PH_ERROR : PH_LITLEN;
					end else if (lit_n > room) begin
						ph_n = PH_ERROR;
					end else if (lit_n == 16'd0) begin
						ph_n = after_lit_f(wp_q, dest_size);
					end else begin
						ph_n = PH_LIT;
					end
				end
				PH_LITLEN: begin
					sum   = {1'b0, lit_q} + {9'd0, in_byte};
					lit_n = sum[15:0];
					if (sum > {1'b0, room}) begin
						ph_n = PH_ERROR;
					end else if (in_byte != 8'hff || last_in) begin
						if (sum[15:0] == 16'd0) begin
							ph_n = after_lit_f(wp_q, dest_size);
						end else begin
							ph_n = PH_LIT;
						end
					end
				end
				PH_LIT: begin
					cmd.kind = CMD_LIT;
					cmd.lit  = in_byte;
					cmd.wp   = wp_q;
					wp_n  = wp_q + 16'd1;
					lit_n = lit_q - 16'd1;
					if (lit_n == 16'd0) begin
						ph_n = after_lit_f(wp_n, dest_size);
					end
				end
				PH_OFFLO: begin
					off_n = {8'd0, in_byte};
					ph_n  = PH_OFFHI;
				end
				PH_OFFHI: begin
					off_n = {in_byte, off_q[7:0]};
					if (off_n == 16'd0 || off_n > wp_q) begin
						ph_n = PH_ERROR;
					end else if (tok_q[3:0] == 4'hf && !last_in) begin
						ml_n = 16'd15;
						ph_n = PH_MATLEN;
					end else begin
						ml = {12'd0, tok_q[3:0]} + 16'd4;
						if (ml > room) begin
							ml = room;
						end
						ml_n = ml;
						ph_n = (ml == 16'd0) ? PH_DONE : PH_COPY;
					end
				end
				PH_MATLEN: begin
					sum  = {1'b0, ml_q} + {9'd0, in_byte};
					ml   = sum[16] ? 16'hffff : sum[15:0];
					ml_n = ml;
					if (in_byte != 8'hff || last_in) begin
						sum = {1'b0, ml} + 17'd4;
						ml  = sum[16] ? 16'hffff : sum[15:0];
						if (ml > room) begin
							ml = room;
						end
						ml_n = ml;
						ph_n = (ml == 16'd0) ? PH_DONE : PH_COPY;
					end
				end
				default: begin
					ph_n = PH_ERROR;
				end
			endcase
			do_copy = (ph_n == PH_COPY);
		end

		// copy run of this request, clipped to the per-request limit
		if (do_copy) begin
			n = (ml_n < 16'(MAX_BYTES_PER_ITEM)) ? ml_n[CNT_W-1:0]
				: CNT_W'(MAX_BYTES_PER_ITEM);
			cmd.kind = CMD_COPY;
			cmd.cnt  = n;
			cmd.off  = off_n;
			cmd.wp   = wp_n;
			ml_n = ml_n - {{(16-CNT_W){1'b0}}, n};
			wp_n = wp_n + {{(16-CNT_W){1'b0}}, n};
			if (ml_n == 16'd0) begin
				ph_n = (wp_n >= dest_size) ? PH_DONE : PH_TOKEN;
			end
		end

		// source ran out while more compressed bytes are needed
		if (src_n && (ph_n == PH_TOKEN || ph_n == PH_LITLEN || ph_n == PH_LIT
			|| ph_n == PH_OFFLO || ph_n == PH_OFFHI || ph_n == PH_MATLEN)) begin
			ph_n = PH_ERROR;
		end

		if (busy) begin
			cmd.status = ST_BUSY;
		end else if (ph_n == PH_COPY) begin
			cmd.status = ST_PENDING;
		end else if (ph_n == PH_DONE) begin
			cmd.status = ST_DONE;
		end else if (ph_n == PH_ERROR) begin
			cmd.status = ST_ERROR;
		end else begin
			cmd.status = ST_OK;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_TOKEN;
			wp_q  <= '0;
			tok_q <= '0;
			lit_q <= '0;
			ml_q  <= '0;
			off_q <= '0;
			src_q <= 1'b0;
		end else if (accept) begin
			ph_q  <= ph_n;
			wp_q  <= wp_n;
			tok_q <= tok_n;
			lit_q <= lit_n;
			ml_q  <= ml_n;
			off_q <= off_n;
			src_q <= src_n;
		end
	end

endmodule

`default_nettype wire

// ----- src/lz4d_back.sv -----
// copy engine: writes literals, copies matches from history, drives results
// depends on lz4d_pkg and lz4d_ram
`default_nettype none

module lz4d_back #(
	parameter int HISTORY_DEPTH = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  lz4d_pkg::cmd_t   cmd,
	input  wire logic        cmd_valid,
	output logic             cmd_pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);
	import lz4d_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_RD   = 3'b010,
		B_WR   = 3'b100
	} bstate_t;

	bstate_t          state_q;
	logic [15:0]      wp_q;
	logic [15:0]      off_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       st_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_has_q;
	logic [2:0]       out_st_q;
	logic             out_last_q;

	logic       out_free;
	logic       emit;
	logic [7:0] emit_byte;
	logic       emit_has;
	logic [2:0] emit_st;
	logic       emit_last;
	logic       ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0] ram_wdata;
	logic       ram_re;
	logic [15:0] src_addr;
	logic [7:0] ram_rdata;

	assign out_free = !out_valid_q || m_tready;
	assign src_addr = wp_q - off_q;

	lz4d_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (src_addr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// command execution
	always_comb begin
		cmd_pop   = 1'b0;
		emit      = 1'b0;
		emit_byte = 8'd0;
		emit_has  = 1'b0;
		emit_st   = st_q;
		emit_last = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = wp_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						CMD_LIT: begin
							emit      = 1'b1;
							emit_byte = cmd.lit;
							emit_has  = 1'b1;
							emit_st   = cmd.status;
							emit_last = 1'b1;
							ram_we    = 1'b1;
							ram_waddr = cmd.wp[AW-1:0];
							ram_wdata = cmd.lit;
						end
						CMD_COPY: begin
						end
						default: begin
							emit      = 1'b1;
							emit_st   = cmd.status;
							emit_last = 1'b1;
						end
					endcase
				end
			end
			B_RD: begin
				ram_re = 1'b1;
			end
			B_WR: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_byte = ram_rdata;
					emit_has  = 1'b1;
					emit_last = (cnt_q == CNT_W'(1));
					ram_we    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (cmd_pop && cmd.kind == CMD_COPY) begin
						cnt_q   <= cmd.cnt;
						state_q <= B_RD;
					end
				end
				B_RD: begin
					state_q <= B_WR;
				end
				B_WR: begin
					if (out_free) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= (cnt_q == CNT_W'(1)) ? B_IDLE : B_RD;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// copy pointers
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.kind == CMD_COPY) begin
			wp_q  <= cmd.wp;
			off_q <= cmd.off;
			st_q  <= cmd.status;
		end else if (state_q == B_WR && out_free) begin
			wp_q <= wp_q + 16'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_has_q  <= emit_has;
			out_st_q   <= emit_st;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_st_q, out_byte_q};
	assign m_tuser  = out_has_q;
	assign m_tlast  = out_last_q;

	// checks
	a_wr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_WR |-> cnt_q != '0)
		else $error("copy write with zero count");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> state_q == B_IDLE)
		else $error("command taken while busy");
	a_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_RD |=> state_q == B_WR)
		else $error("read not followed by write");

endmodule

`default_nettype wire

// ----- src/lz4_block_decoder.sv -----
// lz4 block decoder top level: config register, parser, queue, copy engine
// depends on lz4d_pkg, lz4d_front, lz4d_cmd_fifo, lz4d_back, lz4d_ram
`default_nettype none

// Takes one compressed byte (tuser 0) or one drain tick (tuser 1) per request
// and returns one or more results per request, the last marked by tlast.
// The parser takes a request per cycle while its two-entry queue has room;
// the copy engine then turns a literal or empty command straight into a result,
// and handles each match byte in a history read step, then a write and output
// step, as set by the registered read of the single history memory, after
// first taking the copy command while idle; results wait while tready is low.
// Up to MAX_BYTES_PER_ITEM match bytes come per request; status 1 asks for
// drain ticks to continue. dest_size lies at address 0 and must be written only
// while idle; the block itself does not enforce this.
module lz4_block_decoder #(
	parameter int HISTORY_DEPTH      = 65536,
	parameter int MAX_BYTES_PER_ITEM = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tuser,   // [0] req_type
	input  wire logic        s_tlast,   // last_in
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // [7:0] data_byte, [10:8] status
	output logic             m_tuser,   // [0] has_data
	output logic             m_tlast    // last_of_run
);
	import lz4d_pkg::*;

	logic [15:0] dest_q;
	logic        accept;
	logic        q_full;
	logic        q_valid;
	logic        q_pop;
	cmd_t        f_cmd;
	cmd_t        q_cmd;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_q <= 16'hffff;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			dest_q <= pwdata[15:0];
		end
	end
	assign prdata = paddr[2] ? 32'd0 : {16'd0, dest_q};

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	lz4d_front #(.MAX_BYTES_PER_ITEM(MAX_BYTES_PER_ITEM)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.dest_size (dest_q),
		.accept    (accept),
		.req_type  (s_tuser),
		.in_byte   (s_tdata),
		.last_in   (s_tlast),
		.cmd       (f_cmd)
	);

	lz4d_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_cmd  (f_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_cmd   (q_cmd),
		.pop_valid (q_valid)
	);

	lz4d_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire
